@@ design/cwlc_pkg.sv @@
package cwlc_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int MIN_VERTICES     = 3;

    localparam int VCOUNT_BITS = 5;
    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 5'd4;

    localparam int CMD_BITS = 2;
    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_NEXT  = 2'd2;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VCOUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDING = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERD,
        S_EVTX,
        S_EDN,
        S_EWN,
        S_EDEC,
        S_CMUL,
        S_CRES,
        S_FIN,
        S_CHK,
        S_DMUL,
        S_DDIV,
        S_DFIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        CTX_IN,
        CTX_OUT,
        CTX_FIN
    } t_ctx;

endpackage

@@ design/convex_window_line_clipper_unit.sv @@
// Channel   | Direction | Handshake                 | Payload
// command   | in        | start high, busy low      | i_cmd, i_vertex_index, i_coord_x/y
// result    | out       | o_strobe, one cycle       | o_clip_start_x/y, o_clip_end_x/y
// config    | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
// Load, start and unused commands leave busy low.
// A next-point command holds busy while it reads and tests each window edge in turn, plus
// a partial-product multiply and compare for each edge whose entry or exit fraction needs a
// compare, then runs the final compare and checks (the checks alone unless both bounds exist)
// and the two endpoint divisions (restoring, one quotient bit a cycle); the one-cycle result
// strobe follows, unless the line is rejected, which ends busy with no strobe.
// Window vertices sit in one synchronous memory, one edge read per pass.
// Reset is synchronous, active low; the receiver cannot stall results.
module convex_window_line_clipper_unit
    import cwlc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [CMD_BITS-1:0]             i_cmd,
    input  logic [3:0]                      i_vertex_index,
    input  logic signed [COORD_BITS-1:0]    i_coord_x,
    input  logic signed [COORD_BITS-1:0]    i_coord_y,
    output logic                            o_strobe,
    output logic signed [COORD_BITS-1:0]    o_clip_start_x,
    output logic signed [COORD_BITS-1:0]    o_clip_start_y,
    output logic signed [COORD_BITS-1:0]    o_clip_end_x,
    output logic signed [COORD_BITS-1:0]    o_clip_end_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        i_cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int W   = C + 1;          // differences
    localparam int H   = C + 1;          // half word for partial products
    localparam int M   = 2 * H;          // fraction magnitudes
    localparam int D   = M + 1;          // signed fraction numerators
    localparam int PW  = H + M;          // endpoint product
    localparam int AW  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW  = AW + 1;
    localparam int DCW = $clog2(H + 1);

    t_state r_state, n_state;

    logic [VCOUNT_BITS-1:0] r_vcount;
    logic                   r_winding;
    logic signed [C-1:0]    r_prev_x, r_prev_y;

    logic [2*C-1:0] r_mem [MAX_VERTICES];
    logic [2*C-1:0] r_va, r_vb;

    logic signed [C-1:0] r_x1, r_y1;
    logic signed [W-1:0] r_dx, r_dy;
    logic signed [W-1:0] r_nx, r_ny, r_wx, r_wy;
    logic signed [D-1:0] r_dn, r_wn;
    logic [AW-1:0]       r_edge;

    logic                r_has_in, r_has_out;
    logic signed [D-1:0] r_in_n, r_out_n;
    logic [M-1:0]        r_in_d, r_out_d;

    logic signed [D-1:0] r_ca, r_cc;
    logic [M-1:0]        r_cb, r_cd;
    t_ctx                r_ctx;
    logic [2*M-1:0]      r_acc1, r_acc2;
    logic [1:0]          r_k;

    logic [M-1:0]        r_lo_n, r_lo_d, r_hi_n, r_hi_d;
    logic                r_pass;
    logic [PW-1:0]       r_accx, r_accy;
    logic [DCW-1:0]      r_cnt;

    logic signed [C-1:0] r_sx, r_sy, r_ex, r_ey;

    // Combinational
    logic          accept, wr_en;
    logic [6:0]    idx_w;
    logic [7:0]    vc_tmp;
    logic [NW-1:0] n_vert, edge_next;
    logic          last_edge;
    logic [AW-1:0] rd_j;

    logic signed [C-1:0] vax, vay, vbx, vby;
    logic signed [W-1:0] ex, ey;
    logic signed [M-1:0] prod_a, prod_b;

    logic                dn_zero, dn_pos, wn_neg, need_cmp;
    logic signed [D-1:0] neg_dn, cand_a;
    logic [M-1:0]        cand_b;

    logic signed [D-1:0] neg_ca, neg_cc;
    logic [M-1:0]        ma, mc;
    logic [H-1:0]        a_part, c_part, b_part, d_part;
    logic [M-1:0]        pp1, pp2;
    logic [1:0]          ks;
    logic [2*M-1:0]      add1, add2;
    logic [1:0]          sa, sc;
    logic                mag_gt, mag_eq, cmp_gt, cmp_eq, cmp_lt;

    logic                rej_chk;
    logic [M-1:0]        num_sel, den_sel;
    logic [H-1:0]        mdx, mdy, num_part;
    logic [M-1:0]        ppx, ppy;
    logic [PW-1:0]       addx, addy;
    logic [M:0]          r2x, r2y;
    logic                gex, gey;
    logic [M:0]          subx, suby;

    logic signed [C+1:0] px, py, qx, qy, bx, by;

    assign accept      = start && !busy;
    assign idx_w       = 7'(i_vertex_index);
    assign wr_en       = accept && (i_cmd == CMD_LOAD) && (idx_w < 7'(MAX_VERTICES));
    assign o_cfg_ready = 1'b1;

    // vertex count clamped to the usable range
    always_comb begin
        vc_tmp = 8'(r_vcount);
        if (vc_tmp < 8'(MIN_VERTICES)) begin
            vc_tmp = 8'(MIN_VERTICES);
        end else if (vc_tmp > 8'(MAX_VERTICES)) begin
            vc_tmp = 8'(MAX_VERTICES);
        end
        n_vert = NW'(vc_tmp);
    end

    assign edge_next = NW'(r_edge) + NW'(1);
    assign last_edge = (edge_next == n_vert);
    assign rd_j      = last_edge ? '0 : edge_next[AW-1:0];

    // edge vectors and inward normal
    assign vax = r_va[2*C-1:C];
    assign vay = r_va[C-1:0];
    assign vbx = r_vb[2*C-1:C];
    assign vby = r_vb[C-1:0];
    assign ex  = W'(vbx) - W'(vax);
    assign ey  = W'(vby) - W'(vay);

    assign prod_a = (r_state == S_EDN) ? M'(r_dx * r_nx) : M'(r_wx * r_nx);
    assign prod_b = (r_state == S_EDN) ? M'(r_dy * r_ny) : M'(r_wy * r_ny);

    // per-edge decision
    assign dn_zero  = (r_dn == '0);
    assign dn_pos   = !r_dn[D-1] && !dn_zero;
    assign wn_neg   = r_wn[D-1];
    assign neg_dn   = -r_dn;
    assign cand_a   = dn_pos ? -r_wn : r_wn;
    assign cand_b   = dn_pos ? r_dn[M-1:0] : neg_dn[M-1:0];
    assign need_cmp = dn_pos ? r_has_in : r_has_out;

    // fraction compare: |a|*d against |c|*b, one partial product pair a cycle
    assign neg_ca = -r_ca;
    assign neg_cc = -r_cc;
    assign ma     = r_ca[D-1] ? neg_ca[M-1:0] : r_ca[M-1:0];
    assign mc     = r_cc[D-1] ? neg_cc[M-1:0] : r_cc[M-1:0];
    assign a_part = r_k[1] ? ma[M-1:H] : ma[H-1:0];
    assign c_part = r_k[1] ? mc[M-1:H] : mc[H-1:0];
    assign d_part = r_k[0] ? r_cd[M-1:H] : r_cd[H-1:0];
    assign b_part = r_k[0] ? r_cb[M-1:H] : r_cb[H-1:0];
    assign pp1    = a_part * d_part;
    assign pp2    = c_part * b_part;
    assign ks     = {1'b0, r_k[1]} + {1'b0, r_k[0]};

    always_comb begin
        case (ks)
            2'd0: begin
                add1 = (2*M)'(pp1);
                add2 = (2*M)'(pp2);
            end
            2'd1: begin
                add1 = (2*M)'(pp1) << H;
                add2 = (2*M)'(pp2) << H;
            end
            default: begin
                add1 = (2*M)'(pp1) << (2 * H);
                add2 = (2*M)'(pp2) << (2 * H);
            end
        endcase
    end

    // sign codes: 0 negative, 1 zero, 2 positive
    assign sa     = r_ca[D-1] ? 2'd0 : ((r_ca == '0) ? 2'd1 : 2'd2);
    assign sc     = r_cc[D-1] ? 2'd0 : ((r_cc == '0) ? 2'd1 : 2'd2);
    assign mag_gt = r_acc1 > r_acc2;
    assign mag_eq = r_acc1 == r_acc2;

    always_comb begin
        if (sa != sc) begin
            cmp_gt = sa > sc;
            cmp_eq = 1'b0;
        end else if (sa == 2'd1) begin
            cmp_gt = 1'b0;
            cmp_eq = 1'b1;
        end else if (sa == 2'd2) begin
            cmp_gt = mag_gt;
            cmp_eq = mag_eq;
        end else begin
            cmp_gt = !mag_gt && !mag_eq;
            cmp_eq = mag_eq;
        end
    end
    assign cmp_lt = !cmp_gt && !cmp_eq;

    assign rej_chk = (r_has_in && (r_in_n > $signed({1'b0, r_in_d})))
                  || (r_has_out && r_out_n[D-1]);

    // endpoint: |d| * num, then restoring division by den in place
    assign num_sel  = r_pass ? r_hi_n : r_lo_n;
    assign den_sel  = r_pass ? r_hi_d : r_lo_d;
    assign mdx      = r_dx[W-1] ? H'(-r_dx) : H'(r_dx);
    assign mdy      = r_dy[W-1] ? H'(-r_dy) : H'(r_dy);
    assign num_part = r_k[0] ? num_sel[M-1:H] : num_sel[H-1:0];
    assign ppx      = mdx * num_part;
    assign ppy      = mdy * num_part;
    assign addx     = r_k[0] ? (PW'(ppx) << H) : PW'(ppx);
    assign addy     = r_k[0] ? (PW'(ppy) << H) : PW'(ppy);

    assign r2x  = {r_accx[PW-1:H], r_accx[H-1]};
    assign r2y  = {r_accy[PW-1:H], r_accy[H-1]};
    assign gex  = r2x >= {1'b0, den_sel};
    assign gey  = r2y >= {1'b0, den_sel};
    assign subx = r2x - {1'b0, den_sel};
    assign suby = r2y - {1'b0, den_sel};

    // truncation toward zero of p + d*t
    assign px = (C+2)'(r_x1);
    assign py = (C+2)'(r_y1);
    assign qx = $signed({1'b0, r_accx[H-1:0]});
    assign qy = $signed({1'b0, r_accy[H-1:0]});

    always_comb begin
        if (!r_dx[W-1]) begin
            bx = px + qx;
            if ((r_accx[PW-1:H] != '0) && bx[C+1]) begin
                bx = bx + (C+2)'(1);
            end
        end else begin
            bx = px - qx;
            if ((r_accx[PW-1:H] != '0) && !bx[C+1] && (bx != '0)) begin
                bx = bx - (C+2)'(1);
            end
        end
        if (!r_dy[W-1]) begin
            by = py + qy;
            if ((r_accy[PW-1:H] != '0) && by[C+1]) begin
                by = by + (C+2)'(1);
            end
        end else begin
            by = py - qy;
            if ((r_accy[PW-1:H] != '0) && !by[C+1] && (by != '0)) begin
                by = by - (C+2)'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_NEXT)) begin
                    n_state = S_ERD;
                end
            end
            S_ERD:  n_state = S_EVTX;
            S_EVTX: n_state = S_EDN;
            S_EDN:  n_state = S_EWN;
            S_EWN:  n_state = S_EDEC;
            S_EDEC: begin
                if (dn_zero && wn_neg) begin
                    n_state = S_IDLE;
                end else if (!dn_zero && need_cmp) begin
                    n_state = S_CMUL;
                end else if (last_edge) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_CMUL: begin
                if (r_k == 2'd3) begin
                    n_state = S_CRES;
                end
            end
            S_CRES: begin
                if (r_ctx == CTX_FIN) begin
                    n_state = cmp_lt ? S_CHK : S_IDLE;
                end else if (last_edge) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_FIN:  n_state = (r_has_in && r_has_out) ? S_CMUL : S_CHK;
            S_CHK:  n_state = rej_chk ? S_IDLE : S_DMUL;
            S_DMUL: begin
                if (r_k[0]) begin
                    n_state = S_DDIV;
                end
            end
            S_DDIV: begin
                if (r_cnt == DCW'(H - 1)) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: n_state = r_pass ? S_OUT : S_DMUL;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy           = (r_state != S_IDLE);
        o_strobe       = (r_state == S_OUT);
        o_clip_start_x = r_sx;
        o_clip_start_y = r_sy;
        o_clip_end_x   = r_ex;
        o_clip_end_y   = r_ey;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= VCOUNT_RESET;
            r_winding <= 1'b0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VCOUNT:  r_vcount  <= i_cfg_data[VCOUNT_BITS-1:0];
                    CFG_WINDING: r_winding <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept && ((i_cmd == CMD_START) || (i_cmd == CMD_NEXT))) begin
                r_prev_x <= i_coord_x;
                r_prev_y <= i_coord_y;
            end
        end
    end

    // window vertex memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[idx_w[AW-1:0]] <= {i_coord_x, i_coord_y};
        end
        if (r_state == S_ERD) begin
            r_va <= r_mem[r_edge];
            r_vb <= r_mem[rd_j];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if ((n_state == S_ERD) && (r_state != S_IDLE)) begin
            r_edge <= r_edge + AW'(1);
        end
        if ((n_state == S_CMUL) && (r_state != S_CMUL)) begin
            r_acc1 <= '0;
            r_acc2 <= '0;
            r_k    <= '0;
        end
        if ((n_state == S_DMUL) && (r_state != S_DMUL)) begin
            r_accx <= '0;
            r_accy <= '0;
            r_k    <= '0;
        end
        if ((n_state == S_DDIV) && (r_state != S_DDIV)) begin
            r_cnt <= '0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_NEXT)) begin
                    r_x1      <= r_prev_x;
                    r_y1      <= r_prev_y;
                    r_dx      <= W'(i_coord_x) - W'(r_prev_x);
                    r_dy      <= W'(i_coord_y) - W'(r_prev_y);
                    r_edge    <= '0;
                    r_has_in  <= 1'b0;
                    r_has_out <= 1'b0;
                    r_pass    <= 1'b0;
                end
            end
            S_EVTX: begin
                r_nx <= r_winding ? ey : -ey;
                r_ny <= r_winding ? -ex : ex;
                r_wx <= W'(r_x1) - W'(vax);
                r_wy <= W'(r_y1) - W'(vay);
            end
            S_EDN: r_dn <= D'(prod_a) + D'(prod_b);
            S_EWN: r_wn <= D'(prod_a) + D'(prod_b);
            S_EDEC: begin
                if (!dn_zero) begin
                    if (need_cmp) begin
                        r_ca  <= cand_a;
                        r_cb  <= cand_b;
                        r_cc  <= dn_pos ? r_in_n : r_out_n;
                        r_cd  <= dn_pos ? r_in_d : r_out_d;
                        r_ctx <= dn_pos ? CTX_IN : CTX_OUT;
                    end else if (dn_pos) begin
                        r_in_n   <= cand_a;
                        r_in_d   <= cand_b;
                        r_has_in <= 1'b1;
                    end else begin
                        r_out_n   <= cand_a;
                        r_out_d   <= cand_b;
                        r_has_out <= 1'b1;
                    end
                end
            end
            S_CMUL: begin
                r_acc1 <= r_acc1 + add1;
                r_acc2 <= r_acc2 + add2;
                r_k    <= r_k + 2'd1;
            end
            S_CRES: begin
                if ((r_ctx == CTX_IN) && cmp_gt) begin
                    r_in_n <= r_ca;
                    r_in_d <= r_cb;
                end
                if ((r_ctx == CTX_OUT) && cmp_lt) begin
                    r_out_n <= r_ca;
                    r_out_d <= r_cb;
                end
            end
            S_FIN: begin
                r_ca  <= r_in_n;
                r_cb  <= r_in_d;
                r_cc  <= r_out_n;
                r_cd  <= r_out_d;
                r_ctx <= CTX_FIN;
            end
            S_CHK: begin
                if (r_has_in && !r_in_n[D-1] && (r_in_n != '0)) begin
                    r_lo_n <= r_in_n[M-1:0];
                    r_lo_d <= r_in_d;
                end else begin
                    r_lo_n <= '0;
                    r_lo_d <= M'(1);
                end
                if (r_has_out && (r_out_n < $signed({1'b0, r_out_d}))) begin
                    r_hi_n <= r_out_n[M-1:0];
                    r_hi_d <= r_out_d;
                end else begin
                    r_hi_n <= M'(1);
                    r_hi_d <= M'(1);
                end
            end
            S_DMUL: begin
                r_accx <= r_accx + addx;
                r_accy <= r_accy + addy;
                r_k    <= r_k + 2'd1;
            end
            S_DDIV: begin
                r_accx <= {(gex ? subx[M-1:0] : r2x[M-1:0]), r_accx[H-2:0], gex};
                r_accy <= {(gey ? suby[M-1:0] : r2y[M-1:0]), r_accy[H-2:0], gey};
                r_cnt  <= r_cnt + DCW'(1);
            end
            S_DFIN: begin
                if (r_pass) begin
                    r_ex <= bx[C-1:0];
                    r_ey <= by[C-1:0];
                end else begin
                    r_sx <= bx[C-1:0];
                    r_sy <= by[C-1:0];
                end
                r_pass <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ design/cwlc_checker.sv @@
module cwlc_checker
    import cwlc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [CMD_BITS-1:0] i_cmd,
    input logic                o_strobe
);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a busy period");

    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy && !o_strobe)
        else $error("block still busy after its result");

    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd != CMD_NEXT)) |=> !busy)
        else $error("single-cycle command raised busy");

    a_next_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_NEXT)) |=> busy)
        else $error("next-point transfer did not start clipping");

endmodule

bind convex_window_line_clipper_unit cwlc_checker u_cwlc_checker (.*);
